### src/gfse_pkg.sv
package gfse_pkg;

   localparam int MAX_GLYPHS_DEF = 4096;

   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   // where the response byte comes from
   typedef enum logic [2:0] {
      BSEL_CONST   = 3'd0,
      BSEL_GLYPH   = 3'd1,
      BSEL_RUN_HI  = 3'd2,
      BSEL_RUN_LO  = 3'd3,
      BSEL_RUN_IDX = 3'd4
   } bsel_type;

   localparam logic [1:0] FMT_RAW   = 2'd0;
   localparam logic [1:0] FMT_RANGE = 2'd3;

   typedef struct packed {
      bsel_type   bsel;
      logic [7:0] cbyte;
      logic       valid;
      logic       last;
   } sel_type;

   typedef struct packed {
      logic [1:0]  fmt;
      logic [12:0] run_total;
      logic [13:0] enc_size;
      logic        ovf;
   } status_type;

   typedef struct packed {
      logic glyph_we;
      logic run_we;
      logic glyph_re;
      logic run_re;
   } mem_ctl_type;

endpackage

### src/gfse_store.sv
module gfse_store #(
   parameter int MAX_GLYPHS = gfse_pkg::MAX_GLYPHS_DEF,
   parameter int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
   input  logic                 clock,
   input  gfse_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]        glyph_waddr,
   input  logic [7:0]           glyph_wdata,
   input  logic [AW-1:0]        glyph_raddr,
   input  logic [AW-1:0]        run_waddr,
   input  logic [AW+7:0]        run_wdata,
   input  logic [AW-1:0]        run_raddr,
   output logic [7:0]           glyph_rdata,
   output logic [AW+7:0]        run_rdata
);

   logic [7:0]    glyph_mem [MAX_GLYPHS];
   // run entry: {first glyph, font index}
   logic [AW+7:0] run_mem [MAX_GLYPHS];

   logic [7:0]    glyph_rd_ff;
   logic [AW+7:0] run_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.glyph_we) begin
         glyph_mem[glyph_waddr] <= glyph_wdata;
      end
      if (mem_ctl.glyph_re) begin
         glyph_rd_ff <= glyph_mem[glyph_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      if (mem_ctl.run_re) begin
         run_rd_ff <= run_mem[run_raddr];
      end
   end

   assign glyph_rdata = glyph_rd_ff;
   assign run_rdata   = run_rd_ff;

endmodule

### src/gfse_ctrl.sv
module gfse_ctrl #(
   parameter int MAX_GLYPHS = gfse_pkg::MAX_GLYPHS_DEF,
   parameter int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            cmd,
   input  logic [7:0]            fd_value,
   output gfse_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]         glyph_waddr,
   output logic [7:0]            glyph_wdata,
   output logic [AW-1:0]         glyph_raddr,
   output logic [AW-1:0]         run_waddr,
   output logic [AW+7:0]         run_wdata,
   output logic [AW-1:0]         run_raddr,
   output gfse_pkg::sel_type     sel,
   output gfse_pkg::status_type  status
);

   localparam int CW = $clog2(MAX_GLYPHS + 1);
   localparam int SW = $clog2(5 + 3 * MAX_GLYPHS + 1);

   logic [CW-1:0] gc_ff, gc_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic [7:0]    prev_ff, prev_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [CW-1:0] run_ff, run_in;
   logic [1:0]    phase_ff, phase_in;
   logic          ovf_ff, ovf_in;
   gfse_pkg::sel_type sel_ff, sel_in;

   logic [SW-1:0] size0, size3, size;
   logic          use3, rd_ok, adv;
   logic [15:0]   gc16, rc16;
   gfse_pkg::bsel_type bsel;
   logic [7:0]    cbyte;
   logic          glyph_rd, run_rd;

   assign size0 = SW'(gc_ff) + SW'(1);
   assign size3 = (SW'(rc_ff) << 1) + SW'(rc_ff) + SW'(5);
   assign use3  = size0 > size3;
   assign size  = use3 ? size3 : size0;
   assign rd_ok = pos_ff < size;
   assign gc16  = 16'(gc_ff);
   assign rc16  = 16'(rc_ff);

   // byte source for the current read position
   always_comb begin
      bsel     = gfse_pkg::BSEL_CONST;
      cbyte    = 8'd0;
      glyph_rd = 1'b0;
      run_rd   = 1'b0;
      adv      = 1'b0;
      if (!use3) begin
         if (pos_ff != '0) begin
            bsel     = gfse_pkg::BSEL_GLYPH;
            glyph_rd = 1'b1;
         end
      end else if (pos_ff == SW'(0)) begin
         cbyte = 8'(gfse_pkg::FMT_RANGE);
      end else if (pos_ff == SW'(1)) begin
         cbyte = rc16[15:8];
      end else if (pos_ff == SW'(2)) begin
         cbyte = rc16[7:0];
      end else begin
         adv = 1'b1;
         if (run_ff < rc_ff) begin
            run_rd = 1'b1;
            case (phase_ff)
               2'd0:    bsel = gfse_pkg::BSEL_RUN_HI;
               2'd1:    bsel = gfse_pkg::BSEL_RUN_LO;
               default: bsel = gfse_pkg::BSEL_RUN_IDX;
            endcase
         end else begin
            // sentinel: glyph count, big-endian
            cbyte = (phase_ff == 2'd0) ? gc16[15:8] : gc16[7:0];
         end
      end
   end

   always_comb begin
      gc_in    = gc_ff;
      rc_in    = rc_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      ovf_in   = ovf_ff;
      sel_in   = sel_ff;
      mem_ctl  = '0;
      if (accept) begin
         sel_in.bsel  = gfse_pkg::BSEL_CONST;
         sel_in.cbyte = 8'd0;
         sel_in.valid = 1'b0;
         sel_in.last  = 1'b0;
         case (cmd)
            gfse_pkg::CMD_BEGIN: begin
               gc_in    = '0;
               rc_in    = '0;
               prev_in  = '0;
               pos_in   = '0;
               run_in   = '0;
               phase_in = '0;
               ovf_in   = 1'b0;
            end
            gfse_pkg::CMD_APPEND: begin
               if (pos_ff == '0) begin
                  if (gc_ff == CW'(MAX_GLYPHS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     mem_ctl.glyph_we = 1'b1;
                     gc_in            = gc_ff + CW'(1);
                     prev_in          = fd_value;
                     if (gc_ff == '0 || fd_value != prev_ff) begin
                        mem_ctl.run_we = 1'b1;
                        rc_in          = rc_ff + CW'(1);
                     end
                  end
               end
            end
            gfse_pkg::CMD_READ: begin
               if (rd_ok) begin
                  sel_in.bsel      = bsel;
                  sel_in.cbyte     = cbyte;
                  sel_in.valid     = 1'b1;
                  sel_in.last      = (pos_ff + SW'(1)) == size;
                  mem_ctl.glyph_re = glyph_rd;
                  mem_ctl.run_re   = run_rd;
                  pos_in           = pos_ff + SW'(1);
                  if (adv) begin
                     if (phase_ff == 2'd2) begin
                        phase_in = 2'd0;
                        run_in   = run_ff + CW'(1);
                     end else begin
                        phase_in = phase_ff + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff    <= '0;
         rc_ff    <= '0;
         prev_ff  <= '0;
         pos_ff   <= '0;
         run_ff   <= '0;
         phase_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         gc_ff    <= gc_in;
         rc_ff    <= rc_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         run_ff   <= run_in;
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
   end

   assign glyph_waddr = AW'(gc_ff);
   assign glyph_wdata = fd_value;
   assign glyph_raddr = AW'(pos_ff - SW'(1));
   assign run_waddr   = AW'(rc_ff);
   assign run_wdata   = {AW'(gc_ff), fd_value};
   assign run_raddr   = AW'(run_ff);

   assign sel              = sel_ff;
   assign status.fmt       = use3 ? gfse_pkg::FMT_RANGE : gfse_pkg::FMT_RAW;
   assign status.run_total = 13'(rc_ff);
   assign status.enc_size  = 14'(size);
   assign status.ovf       = ovf_ff;

endmodule

### src/glyph_font_selector_encoder_top.sv
// Font-dictionary selector table encoder. Requests carry a command in req_tuser
// (begin, append, read) and a font index in req_tdata; every request returns
// exactly one response with the status fields, and a read returns the next byte
// of the smaller of format 0 (raw indices) or format 3 (ranges), format 0 on a
// tie. Glyph indices and run records live in two synchronous memories sized by
// MAX_GLYPHS. On the accepting edge a request updates the counters and issues
// the memory read; in the response state the registered read data is formatted
// into the output register once that register is free. A new request is taken
// only after the previous response has been loaded into the output register.
// A pending response waits there while the next request is accepted.
module glyph_font_selector_encoder_top #(
   parameter int MAX_GLYPHS = gfse_pkg::MAX_GLYPHS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] fd_value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [9:8] format_code, [22:10] run_total,
   // [36:23] encoded_size, [37] overflow_flag, [39:38] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] out_valid
   output logic        rsp_tlast    // out_last
);

   localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept, load;

   gfse_pkg::mem_ctl_type mem_ctl;
   gfse_pkg::sel_type     sel;
   gfse_pkg::status_type  status;
   logic [AW-1:0] glyph_waddr, glyph_raddr, run_waddr, run_raddr;
   logic [7:0]    glyph_wdata, glyph_rdata;
   logic [AW+7:0] run_wdata, run_rdata;
   logic [15:0]   first16;
   logic [7:0]    out_byte;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   gfse_ctrl #(.MAX_GLYPHS(MAX_GLYPHS), .AW(AW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_tuser),
      .fd_value    (req_tdata),
      .mem_ctl     (mem_ctl),
      .glyph_waddr (glyph_waddr),
      .glyph_wdata (glyph_wdata),
      .glyph_raddr (glyph_raddr),
      .run_waddr   (run_waddr),
      .run_wdata   (run_wdata),
      .run_raddr   (run_raddr),
      .sel         (sel),
      .status      (status)
   );

   gfse_store #(.MAX_GLYPHS(MAX_GLYPHS), .AW(AW)) u_store (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .glyph_waddr (glyph_waddr),
      .glyph_wdata (glyph_wdata),
      .glyph_raddr (glyph_raddr),
      .run_waddr   (run_waddr),
      .run_wdata   (run_wdata),
      .run_raddr   (run_raddr),
      .glyph_rdata (glyph_rdata),
      .run_rdata   (run_rdata)
   );

   assign first16 = 16'(run_rdata[AW+7:8]);

   always_comb begin
      case (sel.bsel)
         gfse_pkg::BSEL_GLYPH:   out_byte = glyph_rdata;
         gfse_pkg::BSEL_RUN_HI:  out_byte = first16[15:8];
         gfse_pkg::BSEL_RUN_LO:  out_byte = first16[7:0];
         gfse_pkg::BSEL_RUN_IDX: out_byte = run_rdata[7:0];
         default:                out_byte = sel.cbyte;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, status.ovf, status.enc_size, status.run_total,
                               status.fmt, out_byte};
               rsp_user_in  = sel.valid;
               rsp_last_in  = sel.last;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while previous one in flight");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last flag on a response without a byte");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("nonzero byte on a response without data");

   a_format_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:8] == gfse_pkg::FMT_RAW ||
                      rsp_tdata[9:8] == gfse_pkg::FMT_RANGE))
      else $error("bad format code");

endmodule
